@@ rtl/ekbd_pkg.sv @@
// Package for the emulated keyboard buffer device.
// Holds beat types, event and command codes, the buffer geometry and the key translation.
// No dependencies.
package ekbd_pkg;

    // Buffer geometry
    localparam int BUFFER_DEPTH = 16;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);

    // Event modes
    localparam logic [1:0] MODE_KEY_DOWN = 2'd0;
    localparam logic [1:0] MODE_KEY_UP   = 2'd1;
    localparam logic [1:0] MODE_COMMAND  = 2'd2;

    // Bus command numbers (register A)
    localparam logic [15:0] CMD_CLEAR   = 16'd0;
    localparam logic [15:0] CMD_POP     = 16'd1;
    localparam logic [15:0] CMD_SET_IRQ = 16'd3;

    // Host key codes with fixed device codes
    localparam logic [7:0] K_BACKSPACE = 8'h08;
    localparam logic [7:0] K_RETURN    = 8'h0D;
    localparam logic [7:0] K_DELETE    = 8'h2E;
    localparam logic [7:0] K_UP        = 8'h26;
    localparam logic [7:0] K_DOWN      = 8'h28;
    localparam logic [7:0] K_LEFT      = 8'h25;
    localparam logic [7:0] K_RIGHT     = 8'h27;
    localparam logic [7:0] K_SHIFT     = 8'h10;
    localparam logic [7:0] K_CONTROL   = 8'h11;

    // Input beat
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  key_code;
        logic [15:0] reg_a;
        logic [15:0] reg_b;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic       reply_valid;
        logic [7:0] reply_data;
        logic       key_valid;
        logic [7:0] key_char;
        logic       irq_fire;
    } t_out_beat;

    // Controller to datapath commands
    typedef struct packed {
        logic load;           // capture a result beat
        logic push;           // key down: translate and store
        logic shift_set;      // key down of shift
        logic shift_release;  // key up of shift
        logic clear;          // empty the buffer
        logic pop;            // pop request (reply even when empty)
        logic set_irq;        // latch interrupt enable from register B
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic buf_empty;
    } t_dp_status;

    // Shifted US layout for punctuation and digits
    function automatic logic [7:0] ekbd_shifted(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h60:   r = 8'h7E; // ` ~
            8'h31:   r = 8'h21; // 1 !
            8'h32:   r = 8'h40; // 2 @
            8'h33:   r = 8'h23; // 3 #
            8'h34:   r = 8'h24; // 4 $
            8'h35:   r = 8'h25; // 5 %
            8'h36:   r = 8'h5E; // 6 ^
            8'h37:   r = 8'h26; // 7 &
            8'h38:   r = 8'h2A; // 8 *
            8'h39:   r = 8'h28; // 9 (
            8'h30:   r = 8'h29; // 0 )
            8'h2D:   r = 8'h5F; // - _
            8'h3D:   r = 8'h2B; // = +
            8'h5B:   r = 8'h7B; // [ {
            8'h5D:   r = 8'h7D; // ] }
            8'h5C:   r = 8'h7C; // \ |
            8'h3B:   r = 8'h3A; // ; :
            8'h2C:   r = 8'h3C; // , <
            8'h2F:   r = 8'h3F; // / ?
            default: r = c;     // apostrophe and full stop are named keys
        endcase
        return r;
    endfunction

    // Host code to device byte; named keys win over the shift table
    function automatic logic [7:0] ekbd_translate(input logic [7:0] code,
                                                  input logic       shift);
        logic [7:0] r;
        case (code)
            K_BACKSPACE: r = 8'h10;
            K_RETURN:    r = 8'h11;
            K_DELETE:    r = 8'h13;
            K_UP:        r = 8'h80;
            K_DOWN:      r = 8'h81;
            K_LEFT:      r = 8'h82;
            K_RIGHT:     r = 8'h83;
            K_SHIFT:     r = 8'h90;
            K_CONTROL:   r = 8'h91;
            default: begin
                if (shift)
                    r = ekbd_shifted(code);
                else if (code inside {[8'd65:8'd90]})
                    r = code + 8'd32;
                else
                    r = code;
            end
        endcase
        return r;
    endfunction

endpackage

@@ rtl/ekbd_ctrl.sv @@
// Controller for the keyboard buffer device: handshake state and event decode.
// Depends on ekbd_pkg.
module ekbd_ctrl
    import ekbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_beat   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {ST_EMPTY, ST_HOLD} t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // Take a beat unless a held result is stalled
    assign o_in_stall  = (r_state == ST_HOLD) && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == ST_HOLD);

    // Decode the accepted event into datapath commands
    always_comb begin
        o_cmd               = '0;
        o_cmd.load          = w_accept;
        if (w_accept) begin
            case (i_in_data.mode)
                MODE_KEY_DOWN: begin
                    o_cmd.push      = 1'b1;
                    o_cmd.shift_set = (i_in_data.key_code == K_SHIFT);
                end
                MODE_KEY_UP: begin
                    o_cmd.shift_release = (i_in_data.key_code == K_SHIFT);
                end
                MODE_COMMAND: begin
                    o_cmd.clear   = (i_in_data.reg_a == CMD_CLEAR);
                    o_cmd.pop     = (i_in_data.reg_a == CMD_POP);
                    o_cmd.set_irq = (i_in_data.reg_a == CMD_SET_IRQ);
                end
                default: ;  // mode 3 gives an all-zero result
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_EMPTY: if (w_accept) n_state = ST_HOLD;
            ST_HOLD:  if (!w_accept && !i_out_stall) n_state = ST_EMPTY;
            default:  n_state = ST_EMPTY;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted beat always leaves a result waiting
    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_HOLD))
        else $error("accepted beat did not produce a result");

    // Only one buffer command is ever issued per beat
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.push, o_cmd.clear, o_cmd.pop, o_cmd.set_irq, o_cmd.shift_release}))
        else $error("conflicting datapath commands");

    // The buffer status is known whenever a pop is issued
    a_status_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop |-> !$isunknown(i_status.buf_empty))
        else $error("buffer status unknown at pop");

endmodule

@@ rtl/ekbd_dpath.sv @@
// Datapath for the keyboard buffer device: translation, key buffer, flags, result register.
// Depends on ekbd_pkg.
module ekbd_dpath
    import ekbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_beat   i_in_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_beat  o_out_data
);

    logic [7:0]        r_store [BUFFER_DEPTH];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              r_irq_en;
    logic              r_shift;
    t_out_beat         r_out;
    t_out_beat         n_out;
    logic [7:0]        w_char;
    logic [IDX_W-1:0]  w_wr_idx;
    logic [FILL_W-1:0] w_fill_dec;
    logic [IDX_W-1:0]  w_rd_idx;
    logic              w_empty;

    // Buffer pointers; a push on a full buffer wraps to entry 0.
    // Entries below the fill count are always written, so clear needs no sweep.
    assign w_empty    = (r_fill == '0);
    assign w_wr_idx   = (r_fill >= FILL_W'(BUFFER_DEPTH)) ? '0 : r_fill[IDX_W-1:0];
    assign w_fill_dec = r_fill - FILL_W'(1);
    assign w_rd_idx   = w_fill_dec[IDX_W-1:0];
    assign w_char     = ekbd_translate(i_in_data.key_code, r_shift);

    assign o_status.buf_empty = w_empty;
    assign o_out_data         = r_out;

    // Result beat
    always_comb begin
        n_out             = '0;
        n_out.reply_valid = i_cmd.pop;
        n_out.reply_data  = (i_cmd.pop && !w_empty) ? r_store[w_rd_idx] : 8'd0;
        n_out.key_valid   = i_cmd.push;
        n_out.key_char    = i_cmd.push ? w_char : 8'd0;
        n_out.irq_fire    = i_cmd.push && r_irq_en;
    end

    // Fill count
    always_comb begin
        n_fill = r_fill;
        if (i_cmd.clear)
            n_fill = '0;
        else if (i_cmd.push)
            n_fill = FILL_W'(w_wr_idx) + FILL_W'(1);
        else if (i_cmd.pop && !w_empty)
            n_fill = w_fill_dec;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_irq_en <= 1'b0;
            r_shift  <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_cmd.set_irq)       r_irq_en <= (i_in_data.reg_b != 16'd0);
            if (i_cmd.shift_set)     r_shift  <= 1'b1;
            if (i_cmd.shift_release) r_shift  <= 1'b0;
        end
    end

    // Key store and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) r_store[w_wr_idx] <= w_char;
        if (i_cmd.load) r_out             <= n_out;
    end

    // Fill count never passes the depth
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(BUFFER_DEPTH))
        else $error("fill count out of range");

    // A clear leaves the buffer empty
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> w_empty)
        else $error("buffer not empty after clear");

    // A pop on an empty buffer replies with zero
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_cmd.pop && w_empty) |=> (r_out.reply_valid && r_out.reply_data == 8'd0))
        else $error("pop on empty buffer gave non-zero reply");

endmodule

@@ rtl/emulated_keyboard_buffer_device_core.sv @@
// Top level of the emulated keyboard buffer device.
// Depends on ekbd_pkg, ekbd_ctrl and ekbd_dpath.
//
// Each input beat is one event (key down, key up or a bus command) and yields exactly one
// result beat, registered in the cycle after acceptance. The block takes one beat per cycle
// unless a held result is stalled: the result register is refilled in the same cycle that
// its previous result is taken, so o_in_stall follows i_out_stall only while a result is
// waiting. Key translation, buffer write and fill count update all settle on acceptance.
// The 16-entry key buffer needs no clearing pass after reset or a clear command; the fill
// count alone decides what a pop may read, and a pop on an empty buffer replies with zero.
module emulated_keyboard_buffer_device_core
    import ekbd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Handshake and decode
    ekbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Buffer and result
    ekbd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_data (o_out_data)
    );

endmodule
